/* rtl/spl_pkg.sv */
// Package for the strip pixel locator: payload structs, register indexes,
// controller/datapath command and status bundles. No dependencies.
package spl_pkg;

  localparam int MAX_STRIPS_DEF   = 256;
  localparam int WINDOW_BYTES_DEF = 512;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_TOTAL     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USE_WINDOW      = 2'd3;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_LOCATE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [7:0]  entry_index;
    logic [31:0] strip_file_offset;
    logic [31:0] strip_byte_length;
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  strip_index;
    logic [31:0] byte_in_strip;
    logic [31:0] file_address;
    logic        fetch_needed;
    logic [16:0] fetch_length;
    logic [15:0] window_position;
    logic        beyond_image;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic mul_a;       // row * width
    logic mul_b;       // (.. + column) * bytes per pixel
    logic walk_init;
    logic walk_adv;
    logic set_beyond;
    logic calc_off;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_mode;
    logic count_zero;
    logic found;
    logic last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/spl_ctrl.sv */
// Sequencer for the strip pixel locator: accepts items, steps the
// multiply, strip walk and result stages. Uses spl_pkg.
module spl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  spl_pkg::sts_t sts,
  output spl_pkg::cmd_t cmd
);
  import spl_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL1     = 3'd1;
  localparam logic [2:0] ST_MUL2     = 3'd2;
  localparam logic [2:0] ST_WALK_RD  = 3'd3;
  localparam logic [2:0] ST_WALK_CHK = 3'd4;
  localparam logic [2:0] ST_OFFS     = 3'd5;
  localparam logic [2:0] ST_EMIT     = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.in_mode == MODE_LOCATE) begin
            state_nxt = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        cmd.mul_a = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_b     = 1'b1;
        cmd.walk_init = 1'b1;
        if (sts.count_zero) begin
          cmd.set_beyond = 1'b1;
          state_nxt      = ST_EMIT;
        end else begin
          state_nxt = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        state_nxt = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (sts.found) begin
          state_nxt = ST_OFFS;
        end else if (sts.last) begin
          cmd.set_beyond = 1'b1;
          state_nxt      = ST_EMIT;
        end else begin
          cmd.walk_adv = 1'b1;
          state_nxt    = ST_WALK_RD;
        end
      end
      ST_OFFS: begin
        cmd.calc_off = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/spl_dp.sv */
// Datapath for the strip pixel locator: config registers, strip table
// memory, position multiply, walk accumulator, read window, output register.
// Uses spl_pkg; driven by spl_ctrl.
module spl_dp #(
  parameter int MAX_STRIPS   = spl_pkg::MAX_STRIPS_DEF,
  parameter int WINDOW_BYTES = spl_pkg::WINDOW_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  spl_pkg::in_item_t                  in_data,
  input  logic                               cfg_valid,
  input  logic [spl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                               out_valid,
  input  logic                               out_stall,
  output spl_pkg::out_item_t                 out_data,
  input  spl_pkg::cmd_t                      cmd,
  output spl_pkg::sts_t                      sts
);
  import spl_pkg::*;

  localparam int DEPTH = (MAX_STRIPS < 256) ? MAX_STRIPS : 256;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [8:0]  DEPTH_9 = 9'(DEPTH);
  localparam logic [31:0] WB_32   = 32'(WINDOW_BYTES);

  // config
  logic [15:0] image_width_r;
  logic [4:0]  bpp_r;
  logic [8:0]  strip_total_r;
  logic        use_window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= 16'd1;
      bpp_r         <= 5'd1;
      strip_total_r <= 9'd1;
      use_window_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:     image_width_r <= cfg_wdata[15:0];
        REG_BYTES_PER_PIXEL: bpp_r         <= cfg_wdata[4:0];
        REG_STRIP_TOTAL:     strip_total_r <= cfg_wdata[8:0];
        REG_USE_WINDOW:      use_window_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // strip table: {file offset, byte length}, one read port registered
  logic [63:0] tbl_mem [DEPTH];
  logic [63:0] rd_r;
  logic [7:0]  s_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && in_data.mode == MODE_LOAD &&
        {1'b0, in_data.entry_index} < DEPTH_9) begin
      tbl_mem[in_data.entry_index[IDX_W-1:0]] <=
        {in_data.strip_file_offset, in_data.strip_byte_length};
    end
    rd_r <= tbl_mem[s_r[IDX_W-1:0]];
  end

  logic [31:0] ent_start, ent_len;
  assign ent_start = rd_r[63:32];
  assign ent_len   = rd_r[31:0];

  // position
  logic [15:0] x_r, y_r;
  logic [31:0] pos_r, pos_col, pos_nxt;

  assign pos_col = pos_r + {16'd0, x_r};

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.mul_a) begin
      pos_nxt = {16'd0, y_r} * {16'd0, image_width_r};
    end else if (cmd.mul_b) begin
      pos_nxt = pos_col * {27'd0, bpp_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r <= in_data.pixel_x;
      y_r <= in_data.pixel_y;
    end
    pos_r <= pos_nxt;
  end

  // strip walk; the running sum never exceeds the position while walking
  logic [31:0] acc_r;
  logic [32:0] acc_next;
  logic [8:0]  count;
  logic        beyond_r;
  logic [31:0] off_r;

  assign acc_next = {1'b0, acc_r} + {1'b0, ent_len};
  assign count    = (strip_total_r < DEPTH_9) ? strip_total_r : DEPTH_9;

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      s_r   <= 8'd0;
      acc_r <= 32'd0;
    end else if (cmd.walk_adv) begin
      s_r   <= s_r + 8'd1;
      acc_r <= acc_next[31:0];
    end
    if (cmd.walk_init) begin
      beyond_r <= cmd.set_beyond;
    end else if (cmd.set_beyond) begin
      beyond_r <= 1'b1;
    end
    if (cmd.calc_off) begin
      off_r <= pos_r - acc_r;
    end
  end

  assign sts.in_mode    = in_data.mode;
  assign sts.count_zero = (count == 9'd0);
  assign sts.found      = acc_next > {1'b0, pos_r};
  assign sts.last       = ({1'b0, s_r} + 9'd1) >= count;

  // read window
  logic        win_valid_r;
  logic [7:0]  win_strip_r;
  logic [31:0] win_start_r;
  logic [16:0] win_len_r;
  logic        win_hit;
  logic [31:0] remain, win_rel;
  logic [16:0] new_len;
  out_item_t   res;
  logic        win_load;

  assign win_hit = win_valid_r && (win_strip_r == s_r) && (win_start_r <= off_r) &&
                   (({1'b0, win_start_r} + {16'd0, win_len_r}) > {1'b0, off_r});
  assign remain  = ent_len - off_r;
  assign new_len = (remain < WB_32) ? remain[16:0] : WB_32[16:0];
  assign win_rel = off_r - win_start_r;

  always_comb begin
    res          = '0;
    win_load     = 1'b0;
    if (beyond_r) begin
      res.beyond_image = 1'b1;
    end else begin
      res.strip_index   = s_r;
      res.byte_in_strip = off_r;
      res.file_address  = ent_start + off_r;
      if (!use_window_r) begin
        res.fetch_needed = 1'b1;
        res.fetch_length = {12'd0, bpp_r};
      end else if (win_hit) begin
        res.window_position = win_rel[15:0];
      end else begin
        res.fetch_needed = 1'b1;
        res.fetch_length = new_len;
        win_load         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_valid_r <= 1'b0;
      win_strip_r <= 8'd0;
      win_start_r <= 32'd0;
      win_len_r   <= 17'd0;
    end else if (cmd.emit && win_load) begin
      win_valid_r <= 1'b1;
      win_strip_r <= s_r;
      win_start_r <= off_r;
      win_len_r   <= new_len;
    end
  end

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/strip_pixel_locator_with_window.sv */
// Strip pixel locator: a load item writes a strip table entry on its
// transfer. A locate item steps through the multiply states, then walks
// the strips, one registered table read and one compare per strip, then
// works out the offset in the found strip and places its result in the
// output register; a position past all walked strips, or no strips
// configured, gives a beyond-image result. A result still held by the
// receiver delays the next one until it is taken. The strip walk dominates.
// The input is stalled while a locate is in progress; a waiting result does
// not block the next input transfer. Configure only while idle.
// Uses spl_pkg, spl_ctrl and spl_dp.
module strip_pixel_locator_with_window #(
  parameter int MAX_STRIPS   = spl_pkg::MAX_STRIPS_DEF,
  parameter int WINDOW_BYTES = spl_pkg::WINDOW_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  spl_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output spl_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [spl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import spl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  spl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  spl_dp #(
    .MAX_STRIPS   (MAX_STRIPS),
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* rtl/spl_chk.sv */
// Port-level checker for the strip pixel locator, bound to the top level.
// Uses spl_pkg.
module spl_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input spl_pkg::in_item_t              in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input spl_pkg::out_item_t             out_data
);
  import spl_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // past all strips: every other field is zero
  a_beyond_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.beyond_image |->
      out_data.strip_index == 8'd0 && out_data.byte_in_strip == 32'd0 &&
      out_data.file_address == 32'd0 && !out_data.fetch_needed &&
      out_data.fetch_length == 17'd0 && out_data.window_position == 16'd0)
    else $error("beyond-image result has nonzero fields");

  a_fetch_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fetch_needed |-> out_data.window_position == 16'd0)
    else $error("fetch with nonzero window position");

  a_hit_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.fetch_needed |-> out_data.fetch_length == 17'd0)
    else $error("fetch length without fetch");

  // no new result right after a locate transfer
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.mode == MODE_LOCATE |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind strip_pixel_locator_with_window spl_chk u_spl_chk (.*);

/* tb/tb_strip_pixel_locator_with_window.sv */
`timescale 1ns / 1ps
// Self-checking bench for strip_pixel_locator_with_window: loads strip tables, locates
// pixels under several register settings and stall patterns, checks every result.
// Depends on spl_pkg and the block under test only.
module tb_strip_pixel_locator_with_window;
  import spl_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int ITEM_TARGET = 1200;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  strip_pixel_locator_with_window u_top (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow of the block's registers, strip table and read window
  bit [15:0] img_width = 16'd1;
  bit [4:0] pix_bytes = 5'd1;
  bit [8:0] strip_count = 9'd1;
  bit window_on = 1'b0;
  bit [31:0] strip_base [MAX_STRIPS_DEF];
  bit [31:0] strip_len [MAX_STRIPS_DEF];
  bit win_valid = 1'b0;
  bit [7:0] win_strip = '0;
  bit [31:0] win_start = '0;
  bit [16:0] win_len = '0;

  in_item_t items_to_send[$];
  out_item_t expected_locations[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int queued_items = 0;
  int mismatches = 0;
  int n_loads = 0, n_locates = 0, n_hits = 0, n_misses = 0, n_direct = 0, n_beyond = 0;
  int n_settings = 0;
  int quiet_cycles = 0;

  function automatic void step_locator(in_item_t it);
    bit [31:0] pos, off, remain;
    bit [40:0] walked, upto;
    int count, s;
    bit found;
    out_item_t res;
    if (it.mode == MODE_LOAD) begin
      if (it.entry_index < MAX_STRIPS_DEF) begin
        strip_base[it.entry_index] = it.strip_file_offset;
        strip_len[it.entry_index] = it.strip_byte_length;
      end
      n_loads++;
      return;
    end
    n_locates++;
    res = '0;
    found = 1'b0;
    walked = '0;
    s = 0;
    pos = {16'd0, it.pixel_y} * {16'd0, img_width};
    pos = pos + {16'd0, it.pixel_x};
    pos = pos * {27'd0, pix_bytes};
    count = (strip_count < MAX_STRIPS_DEF) ? int'(strip_count) : MAX_STRIPS_DEF;
    // running sum is exact, no 32-bit wrap
    for (int i = 0; i < count && !found; i++) begin
      upto = walked + strip_len[i];
      if (upto > pos) begin
        found = 1'b1;
        s = i;
      end else begin
        walked = upto;
      end
    end
    if (!found) begin
      res.beyond_image = 1'b1;
      n_beyond++;
    end else begin
      off = pos - walked[31:0];
      res.strip_index = s[7:0];
      res.byte_in_strip = off;
      res.file_address = strip_base[s] + off;
      if (!window_on) begin
        res.fetch_needed = 1'b1;
        res.fetch_length = {12'd0, pix_bytes};
        n_direct++;
      end else if (win_valid && win_strip == s[7:0] && win_start <= off &&
                   64'(win_start) + 64'(win_len) > 64'(off)) begin
        res.window_position = 16'(off - win_start);
        n_hits++;
      end else begin
        remain = strip_len[s] - off;
        win_len = (remain < WINDOW_BYTES_DEF) ? remain[16:0] : 17'(WINDOW_BYTES_DEF);
        win_valid = 1'b1;
        win_strip = s[7:0];
        win_start = off;
        res.fetch_needed = 1'b1;
        res.fetch_length = win_len;
        n_misses++;
      end
    end
    expected_locations.insert(expected_locations.size(), res);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (mismatches < 200)
      $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic check_location(out_item_t got);
    out_item_t want;
    if (expected_locations.size() == 0) begin
      report_mismatch("result with nothing outstanding", 64'(got), 64'd0);
      return;
    end
    want = expected_locations.pop_front();
    if (got.strip_index !== want.strip_index)
      report_mismatch("strip_index", 64'(got.strip_index), 64'(want.strip_index));
    if (got.byte_in_strip !== want.byte_in_strip)
      report_mismatch("byte_in_strip", 64'(got.byte_in_strip), 64'(want.byte_in_strip));
    if (got.file_address !== want.file_address)
      report_mismatch("file_address", 64'(got.file_address), 64'(want.file_address));
    if (got.fetch_needed !== want.fetch_needed)
      report_mismatch("fetch_needed", 64'(got.fetch_needed), 64'(want.fetch_needed));
    if (got.fetch_length !== want.fetch_length)
      report_mismatch("fetch_length", 64'(got.fetch_length), 64'(want.fetch_length));
    if (got.window_position !== want.window_position)
      report_mismatch("window_position", 64'(got.window_position),
                      64'(want.window_position));
    if (got.beyond_image !== want.beyond_image)
      report_mismatch("beyond_image", 64'(got.beyond_image), 64'(want.beyond_image));
  endtask

  // input driver: payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) step_locator(in_data);
      if (!in_valid || !in_stall) begin
        if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= items_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_location(out_data);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles", STALL_LIMIT);
        $display("strip_pixel_locator_with_window verification failed");
        $finish;
      end
    end
  end

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IMAGE_WIDTH:     img_width = val[15:0];
      REG_BYTES_PER_PIXEL: pix_bytes = val[4:0];
      REG_STRIP_TOTAL:     strip_count = val[8:0];
      REG_USE_WINDOW:      window_on = val[0];
      default: ;
    endcase
  endtask

  // unused upper data bits carry noise
  task automatic program_regs(bit [15:0] w, bit [4:0] bpp, bit [8:0] tot, bit win);
    put_reg(REG_IMAGE_WIDTH, w);
    put_reg(REG_BYTES_PER_PIXEL, {11'($urandom), bpp});
    put_reg(REG_STRIP_TOTAL, {7'($urandom), tot});
    put_reg(REG_USE_WINDOW, {15'($urandom), win});
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // loads give no result, so keep clocking after the last one is sent
  task automatic settle();
    while (items_to_send.size() != 0 || in_valid || expected_locations.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_idling(int sel);
    case (sel % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 68; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 68; end
      default: begin send_idle_pct = 18; stall_pct = 18; end
    endcase
  endtask

  task automatic push_load(bit [7:0] idx, bit [31:0] base, bit [31:0] len);
    in_item_t it;
    it.mode = MODE_LOAD;
    it.entry_index = idx;
    it.strip_file_offset = base;
    it.strip_byte_length = len;
    it.pixel_x = 16'($urandom);
    it.pixel_y = 16'($urandom);
    items_to_send.insert(items_to_send.size(), it);
    queued_items++;
  endtask

  task automatic push_locate(bit [15:0] x, bit [15:0] y);
    in_item_t it;
    it.mode = MODE_LOCATE;
    it.entry_index = 8'($urandom);
    it.strip_file_offset = $urandom;
    it.strip_byte_length = $urandom;
    it.pixel_x = x;
    it.pixel_y = y;
    items_to_send.insert(items_to_send.size(), it);
    queued_items++;
  endtask

  // Strips of whole rows or random lengths, then raster runs (mostly window
  // hits), scattered pixels, pixels below the last strip, stray table writes.
  task automatic random_phase(int p);
    int n, rps, rows, m, run, x0, y0;
    bit [15:0] w;
    bit [4:0] bpp;
    bit [8:0] tot;
    bit win, rand_len;
    bit [63:0] row_bytes;
    case ($urandom_range(9))
      0: w = 16'hFFFF;
      1: w = 16'($urandom_range(1, 65535));
      default: w = 16'($urandom_range(1, 48));
    endcase
    case ($urandom_range(19))
      0: bpp = 5'd0;
      1: bpp = 5'($urandom_range(17, 31));
      2: bpp = 5'd16;
      default: bpp = 5'($urandom_range(1, 16));
    endcase
    if (p == 5 || p == 17) begin
      n = MAX_STRIPS_DEF;
      tot = (p == 5) ? 9'd256 : 9'h1FF;
    end else begin
      n = $urandom_range(1, 8);
      tot = 9'(n);
    end
    win = ($urandom_range(3) != 0);
    rps = $urandom_range(1, 4);
    rand_len = (p % 3 == 2);
    row_bytes = 64'(w) * 64'(bpp);
    rows = n * rps;
    settle();
    program_regs(w, bpp, tot, win);
    set_idling(p);
    for (int i = 0; i < n; i++) begin
      if (!rand_len)
        push_load(8'(i), $urandom, 32'(64'(rps) * row_bytes));
      else if ($urandom_range(1))
        push_load(8'(i), $urandom, $urandom);
      else
        push_load(8'(i), $urandom, 32'($urandom_range(2000)));
    end
    m = (n == MAX_STRIPS_DEF) ? 12 : $urandom_range(20, 50);
    while (m > 0) begin
      case ($urandom_range(9))
        0: begin
          push_locate(16'($urandom), 16'($urandom));
          m--;
        end
        1: begin
          push_locate(16'($urandom_range(int'(w) - 1)), 16'(rows + $urandom_range(3)));
          m--;
        end
        2: begin
          push_load(8'($urandom), $urandom, $urandom);
          m--;
        end
        default: begin
          x0 = $urandom_range(int'(w) - 1);
          y0 = $urandom_range(rows - 1);
          run = $urandom_range(1, 24);
          for (int i = 0; i < run; i++) push_locate(16'(x0 + i), 16'(y0));
          m -= run;
        end
      endcase
    end
  endtask

  initial begin
    int phase;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: width 1, one byte per pixel, one strip, direct fetch;
    // the strip sits at the top of the address space so addresses wrap
    push_load(8'd0, 32'hFFFF_FFF0, 32'h20);
    push_locate(16'd0, 16'd0);
    push_locate(16'd16, 16'd0);
    push_locate(16'd31, 16'd0);
    push_locate(16'd0, 16'd32);
    push_locate(16'hFFFF, 16'hFFFF);

    // widest rows, 16-byte pixels, window on: hits, misses, short tail window
    settle();
    program_regs(16'hFFFF, 5'd16, 9'd2, 1'b1);
    set_idling(1);
    push_load(8'd0, $urandom, 32'h1000);
    push_load(8'd1, 32'hFFFF_FF00, 32'hFFFF_FFFF);
    push_locate(16'd0, 16'd0);
    push_locate(16'd1, 16'd0);
    push_locate(16'd31, 16'd0);
    push_locate(16'd32, 16'd0);
    push_locate(16'd255, 16'd0);
    push_locate(16'd256, 16'd0);
    push_locate(16'hFFFF, 16'hFFFF);
    push_locate(16'd0, 16'd0);
    push_locate(16'd0, 16'd0);

    // no strips configured: everything lands past the image
    settle();
    program_regs(16'd0, 5'd31, 9'd0, 1'b1);
    set_idling(2);
    push_locate(16'd100, 16'd7);
    push_locate(16'hFFFF, 16'd0);

    // zero bytes per pixel with empty leading strips
    settle();
    program_regs(16'd3, 5'd0, 9'd3, 1'b0);
    set_idling(3);
    push_load(8'd0, $urandom, 32'd0);
    push_load(8'd1, $urandom, 32'd0);
    push_load(8'd2, $urandom, 32'd7);
    push_locate(16'd9, 16'd9);

    phase = 0;
    while (queued_items < ITEM_TARGET) begin
      random_phase(phase);
      phase++;
    end
    settle();
    repeat (600) @(posedge clk);

    $display("covered %0d table loads and %0d locates over %0d register settings",
             n_loads, n_locates, n_settings);
    $display("window hits %0d, window misses %0d, direct fetches %0d, past last strip %0d",
             n_hits, n_misses, n_direct, n_beyond);
    if (mismatches == 0)
      $display("strip_pixel_locator_with_window verification clean");
    else
      $display("strip_pixel_locator_with_window verification failed");
    $finish;
  end

endmodule
